// ===== rtl/msf_pkg.sv =====
package msf_pkg;

  localparam int FrameW = 60;
  localparam int LastSec = 59;

  localparam logic [7:0] MinuteId = 8'h7E;
  localparam logic [8:0] MarkMs = 9'd500;
  localparam logic [8:0] SlotMs = 9'd100;
  localparam logic [8:0] HoldMs = 9'd0;

  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic [FrameW-1:0] a;
    logic [FrameW-1:0] b;
  } frame_t;

  typedef struct packed {
    logic busy;
    logic mark;
    logic [1:0] seg;
  } seq_stat_t;

endpackage

// ===== rtl/msf_in_if.sv =====
interface msf_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [6:0] year_in_century;
  logic [3:0] month;
  logic [4:0] day_of_month;
  logic [2:0] weekday;
  logic [4:0] hour;
  logic [5:0] minute_value;
  logic       summer_time;
  logic [5:0] second_index;

  modport source (
    output valid, opcode, year_in_century, month, day_of_month, weekday, hour,
           minute_value, summer_time, second_index,
    input  ready
  );
  modport sink (
    input  valid, opcode, year_in_century, month, day_of_month, weekday, hour,
           minute_value, summer_time, second_index,
    output ready
  );
endinterface

// ===== rtl/msf_out_if.sv =====
interface msf_out_if;
  logic       valid;
  logic       ready;
  logic       carrier_lvl;
  logic [8:0] seg_ms;
  logic       last_segment;

  modport source (
    output valid, carrier_lvl, seg_ms, last_segment,
    input  ready
  );
  modport sink (
    input  valid, carrier_lvl, seg_ms, last_segment,
    output ready
  );
endinterface

// ===== rtl/msf_time_code_encoder_core.sv =====
// Channel | Dir | Handshake        | Payload
// in_ch   | in  | valid/ready      | opcode, year..minute_value, summer_time, second_index
// out_ch  | out | valid/ready      | carrier_lvl, seg_ms, last_segment
//
// A load transfer rebuilds both frames; it gives no segment.
// A tick at second 0 gives 2 segments, any other tick 4, one per cycle from the
// segment sequencer while out_ch is not stalled.
// The next item is taken in the cycle the last segment moves to the output register.
// rst_n is synchronous, active low: frames clear to zero, no segment pending.
// A stall on out_ch holds the output register and pauses the sequencer.
module msf_time_code_encoder_core (
  input logic       clk,
  input logic       rst_n,
  msf_in_if.sink    in_ch,
  msf_out_if.source out_ch
);
  import msf_pkg::*;

  frame_t    frames;
  seq_stat_t stat;
  logic      take_ok;
  logic      in_fire;
  logic      load;
  logic      tick;

  assign in_ch.ready = take_ok;
  assign in_fire     = in_ch.valid && take_ok;
  assign load        = in_fire && (in_ch.opcode == OpLoad);
  assign tick        = in_fire && (in_ch.opcode == OpTick);

  // frame builder: BCD fields, minute identifier and parity into A/B frames
  msf_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .year_in_century (in_ch.year_in_century),
    .month           (in_ch.month),
    .day_of_month    (in_ch.day_of_month),
    .weekday         (in_ch.weekday),
    .hour            (in_ch.hour),
    .minute_value    (in_ch.minute_value),
    .summer_time     (in_ch.summer_time),
    .frames          (frames)
  );

  // segment sequencer: latches the second's A/B bits at the tick transfer,
  // then steps its segments into the output register
  msf_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (tick),
    .second_index (in_ch.second_index),
    .frames       (frames),
    .take_ok      (take_ok),
    .stat         (stat),
    .out_ch       (out_ch)
  );

`ifndef NO_ASSERTIONS
  // the final segment of a second is always carrier high until the next second
  a_last_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_segment |->
      out_ch.carrier_lvl && (out_ch.seg_ms == HoldMs))
    else $error("last segment is not an open-ended high");

  // the 500 ms mark is only ever a carrier-off segment
  a_mark_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.seg_ms == MarkMs) |->
      !out_ch.carrier_lvl && !out_ch.last_segment)
    else $error("500 ms segment with carrier high");

  // a tick transfer starts the sequencer at its first segment
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> stat.busy && (stat.seg == 2'd0))
    else $error("tick did not start the sequencer");

  // a second-0 sequence never gets past its second segment
  a_mark_len: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy && stat.mark |-> (stat.seg == 2'd0) || (stat.seg == 2'd1))
    else $error("mark sequence overran");
`endif

endmodule

// ===== rtl/msf_frame.sv =====
module msf_frame (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic [6:0]      year_in_century,
  input  logic [3:0]      month,
  input  logic [4:0]      day_of_month,
  input  logic [2:0]      weekday,
  input  logic [4:0]      hour,
  input  logic [5:0]      minute_value,
  input  logic            summer_time,
  output msf_pkg::frame_t frames
);
  import msf_pkg::*;

  // two BCD digits; tens taken mod 10, quotient by reciprocal 205/2048
  function automatic logic [7:0] bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  q;
    logic [3:0]  tens;
    logic [6:0]  rem;
    p    = 15'(v) * 15'd205;
    q    = p[14:11];
    tens = (q >= 4'd10) ? 4'(q - 4'd10) : q;
    rem  = 7'(v - 7'(q) * 7'd10);
    return {tens, rem[3:0]};
  endfunction

  logic [7:0] yr_bcd, mo_bcd, dy_bcd, wd_bcd, hr_bcd, mi_bcd;
  frame_t     frames_r, frames_nxt;

  always_comb begin
    yr_bcd = bcd(year_in_century);
    mo_bcd = bcd(7'(month));
    dy_bcd = bcd(7'(day_of_month));
    wd_bcd = bcd(7'(weekday));
    hr_bcd = bcd(7'(hour));
    mi_bcd = bcd(7'(minute_value));

    frames_nxt = frames_r;
    if (load) begin
      frames_nxt.a = {17'd0, yr_bcd, mo_bcd[4:0], dy_bcd[5:0], wd_bcd[2:0],
                      hr_bcd[5:0], mi_bcd[6:0], MinuteId};
      frames_nxt.b = '0;
      frames_nxt.b[5] = ~^frames_nxt.a[42:35];
      frames_nxt.b[4] = ~^frames_nxt.a[34:24];
      frames_nxt.b[3] = ~^frames_nxt.a[23:21];
      frames_nxt.b[2] = ~^frames_nxt.a[20:8];
      frames_nxt.b[1] = summer_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= '0;
    end else begin
      frames_r <= frames_nxt;
    end
  end

  assign frames = frames_r;

endmodule

// ===== rtl/msf_seq.sv =====
module msf_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [5:0]         second_index,
  input  msf_pkg::frame_t    frames,
  output logic               take_ok,
  output msf_pkg::seq_stat_t stat,
  msf_out_if.source          out_ch
);
  import msf_pkg::*;

  logic       busy_r, busy_nxt;
  logic [1:0] seg_r, seg_nxt;
  logic       mark_r, mark_nxt;
  logic       a_r, a_nxt;
  logic       b_r, b_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_high_r, out_high_nxt;
  logic [8:0] out_ms_r, out_ms_nxt;
  logic       out_last_r, out_last_nxt;

  logic       adv, seg_last, in_data;
  logic [5:0] bit_idx;

  always_comb begin
    adv      = busy_r && (!out_valid_r || out_ch.ready);
    seg_last = mark_r ? (seg_r == 2'd1) : (seg_r == 2'd3);
    take_ok  = !busy_r || (adv && seg_last);

    // second s carries frame bit 59-s; second 0 and out-of-range seconds read as zero
    bit_idx = 6'(LastSec) - second_index;
    in_data = (second_index inside {[6'd1 : 6'(LastSec)]});

    busy_nxt = busy_r;
    seg_nxt  = seg_r;
    mark_nxt = mark_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      seg_nxt  = 2'd0;
      mark_nxt = (second_index == 6'd0);
      a_nxt    = in_data && frames.a[bit_idx];
      b_nxt    = in_data && frames.b[bit_idx];
    end else if (adv) begin
      busy_nxt = !seg_last;
      seg_nxt  = 2'(seg_r + 2'd1);
    end

    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_high_nxt  = out_high_r;
    out_ms_nxt    = out_ms_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = seg_last;
      case (seg_r)
        2'd0: begin
          out_high_nxt = 1'b0;
          out_ms_nxt   = mark_r ? MarkMs : SlotMs;
        end
        2'd1: begin
          out_high_nxt = mark_r ? 1'b1 : !a_r;
          out_ms_nxt   = mark_r ? HoldMs : SlotMs;
        end
        2'd2: begin
          out_high_nxt = !b_r;
          out_ms_nxt   = SlotMs;
        end
        default: begin
          out_high_nxt = 1'b1;
          out_ms_nxt   = HoldMs;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      seg_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      seg_r       <= seg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mark_r     <= mark_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_high_r <= out_high_nxt;
    out_ms_r   <= out_ms_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.carrier_lvl  = out_high_r;
  assign out_ch.seg_ms       = out_ms_r;
  assign out_ch.last_segment = out_last_r;

  assign stat = '{busy: busy_r, mark: mark_r, seg: seg_r};

endmodule
